>>> design/awba_pkg.sv
// ============================================================================
// awba_pkg
// Shared types and constants of the affine warp box-average unit.
// ============================================================================
package awba_pkg;

    // Item and field widths
    localparam int POS_W     = 9;
    localparam int PIX_W     = 24;
    localparam int CH_W      = 8;
    localparam int POS_EXT_W = 13;   // holds any frame dimension up to 4096

    // Fixed-point arithmetic
    localparam int COEF_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int HALF_LSB  = 32768;
    localparam int PROD_W    = COEF_W + POS_W + 1;
    localparam int SUM_W     = PROD_W + 2;
    localparam int RND_W     = SUM_W - FRAC_BITS;

    // Box average over a 2x2 block, one corner per memory bank
    localparam int CORNER_COUNT = 4;
    localparam int CH_SUM_W     = CH_W + 2;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_COEF_XX  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COEF_XY  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_X = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COEF_YX  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COEF_YY  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y = 3'd5;

    localparam logic signed [COEF_W-1:0] COEF_ONE  = 32'sd65536;
    localparam logic signed [COEF_W-1:0] COEF_ZERO = 32'sd0;

    // Request types
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [CH_W-1:0] CH_WHITE = 8'hFF;

    typedef struct packed {
        logic             req_type;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [PIX_W-1:0] pixel_rgb;
    } item_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_xx;
        logic signed [COEF_W-1:0] coef_xy;
        logic signed [COEF_W-1:0] offset_x;
        logic signed [COEF_W-1:0] coef_yx;
        logic signed [COEF_W-1:0] coef_yy;
        logic signed [COEF_W-1:0] offset_y;
    } coef_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

endpackage

>>> design/awba_ram.sv
// ============================================================================
// awba_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module awba_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/awba_front.sv
// ============================================================================
// awba_front
// Accepts items, drops writes that fall outside the frame, and queues the
// rest for the back end.
// ============================================================================
module awba_front #(
    parameter int FRAME_WIDTH  = 512,
    parameter int FRAME_HEIGHT = 512
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_req_type,
    input  logic [awba_pkg::POS_W-1:0]   s_pos_x,
    input  logic [awba_pkg::POS_W-1:0]   s_pos_y,
    input  logic [awba_pkg::PIX_W-1:0]   s_pixel_rgb,
    output awba_pkg::queue_head_t        q_head,
    input  logic                         q_pop
);

    localparam logic [awba_pkg::POS_EXT_W-1:0] WIDTH_EXT  =
        awba_pkg::POS_EXT_W'(FRAME_WIDTH);
    localparam logic [awba_pkg::POS_EXT_W-1:0] HEIGHT_EXT =
        awba_pkg::POS_EXT_W'(FRAME_HEIGHT);

    awba_pkg::item_t             slot_reg [awba_pkg::QUEUE_DEPTH];
    logic [awba_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [awba_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [awba_pkg::QCNT_W-1:0] count_reg, count_next;

    awba_pkg::item_t in_item;
    logic            in_frame;
    logic            accept;
    logic            push;
    logic            pop;

    assign in_item.req_type  = s_req_type;
    assign in_item.pos_x     = s_pos_x;
    assign in_item.pos_y     = s_pos_y;
    assign in_item.pixel_rgb = s_pixel_rgb;

    // A write outside the frame has no effect, so it never enters the queue.
    assign in_frame = ({{(awba_pkg::POS_EXT_W-awba_pkg::POS_W){1'b0}}, s_pos_x} < WIDTH_EXT)
                   && ({{(awba_pkg::POS_EXT_W-awba_pkg::POS_W){1'b0}}, s_pos_y} < HEIGHT_EXT);

    assign s_ready = (count_reg != awba_pkg::QCNT_W'(awba_pkg::QUEUE_DEPTH));
    assign accept  = s_valid && s_ready;
    assign push    = accept && ((s_req_type == awba_pkg::REQ_QUERY) || in_frame);
    assign pop     = q_pop && (count_reg != '0);

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + awba_pkg::QCNT_W'(push) - awba_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    assign q_head.valid = (count_reg != '0);
    assign q_head.item  = slot_reg[rd_ptr_reg];

endmodule

>>> design/awba_back.sv
// ============================================================================
// awba_back
// Executes queued items: affine mapping, rounding, bounds test, banked frame
// access and the 2x2 average, with the result held in an output register.
// ============================================================================
module awba_back #(
    parameter int FRAME_WIDTH  = 512,
    parameter int FRAME_HEIGHT = 512
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  awba_pkg::coef_t            coef,
    input  awba_pkg::queue_head_t      q_head,
    output logic                       q_pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [awba_pkg::CH_W-1:0]  m_out_red,
    output logic [awba_pkg::CH_W-1:0]  m_out_green,
    output logic [awba_pkg::CH_W-1:0]  m_out_blue,
    output logic                       m_inside_res
);

    localparam int HALF_W      = (FRAME_WIDTH + 1) / 2;
    localparam int HALF_H      = (FRAME_HEIGHT + 1) / 2;
    localparam int COL_W       = (HALF_W > 1) ? $clog2(HALF_W) : 1;
    localparam int ROW_W       = (HALF_H > 1) ? $clog2(HALF_H) : 1;
    localparam int BANK_DEPTH  = 2 ** (COL_W + ROW_W);
    localparam int POS_EXT_W_L = awba_pkg::POS_EXT_W;

    localparam logic signed [awba_pkg::RND_W-1:0] SX_MAX =
        awba_pkg::RND_W'(FRAME_WIDTH - 2);
    localparam logic signed [awba_pkg::RND_W-1:0] SY_MAX =
        awba_pkg::RND_W'(FRAME_HEIGHT - 2);
    localparam logic signed [awba_pkg::SUM_W-1:0] ROUND_HALF =
        awba_pkg::SUM_W'(awba_pkg::HALF_LSB);

    logic adv;

    // Stage 1: products
    logic                                  s1_valid_reg;
    awba_pkg::item_t                       s1_item_reg;
    logic signed [awba_pkg::PROD_W-1:0]    s1_pxx_reg, s1_pxy_reg, s1_pyx_reg, s1_pyy_reg;
    logic signed [awba_pkg::POS_W:0]       x_s, y_s;

    // Stage 2: sums
    logic                                  s2_valid_reg;
    awba_pkg::item_t                       s2_item_reg;
    logic signed [awba_pkg::SUM_W-1:0]     s2_vx_reg, s2_vy_reg;
    logic signed [awba_pkg::SUM_W-1:0]     vx_next, vy_next;

    // Stage 3: rounded source coordinates
    logic                                  s3_valid_reg;
    awba_pkg::item_t                       s3_item_reg;
    logic signed [awba_pkg::RND_W-1:0]     s3_sx_reg, s3_sy_reg;
    logic signed [awba_pkg::SUM_W-1:0]     tx, ty;

    // Stage 4: frame read in flight
    logic                                  s4_valid_reg;
    logic                                  s4_query_reg;
    logic                                  s4_inside_reg;

    // Output register
    logic                                  m_valid_reg;
    logic [awba_pkg::CH_W-1:0]             red_reg, green_reg, blue_reg;
    logic                                  inside_reg;

    // Frame access from stage 3
    logic                                  inside_next;
    logic [POS_EXT_W_L-1:0]                wx_ext, wy_ext;
    logic [COL_W:0]                        col_inc;
    logic [ROW_W:0]                        row_inc;
    logic [COL_W-1:0]                      col_even, col_odd;
    logic [ROW_W-1:0]                      row_even, row_odd;
    logic [COL_W+ROW_W-1:0]                waddr;
    logic [1:0]                            wbank;
    logic                                  s3_write;
    logic [awba_pkg::PIX_W-1:0]            rd_data [awba_pkg::CORNER_COUNT];
    logic [awba_pkg::CH_SUM_W-1:0]         sum_r, sum_g, sum_b;

    // The whole pipeline moves when the output register can take a value.
    assign adv   = !m_valid_reg || m_ready;
    assign q_pop = adv && q_head.valid;

    // ---------------- stage 1 ----------------
    assign x_s = $signed({1'b0, q_head.item.pos_x});
    assign y_s = $signed({1'b0, q_head.item.pos_y});

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_item_reg <= q_head.item;
            s1_pxx_reg  <= coef.coef_xx * x_s;
            s1_pxy_reg  <= coef.coef_xy * y_s;
            s1_pyx_reg  <= coef.coef_yx * x_s;
            s1_pyy_reg  <= coef.coef_yy * y_s;
        end
    end

    // ---------------- stage 2 ----------------
    always_comb begin
        vx_next = awba_pkg::SUM_W'(s1_pxx_reg) + awba_pkg::SUM_W'(s1_pxy_reg)
                + awba_pkg::SUM_W'(coef.offset_x);
        vy_next = awba_pkg::SUM_W'(s1_pyx_reg) + awba_pkg::SUM_W'(s1_pyy_reg)
                + awba_pkg::SUM_W'(coef.offset_y);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_item_reg <= s1_item_reg;
            s2_vx_reg   <= vx_next;
            s2_vy_reg   <= vy_next;
        end
    end

    // ---------------- stage 3 ----------------
    // Half away from zero equals floor((v + 0.5 - lsb) / 1.0) for negative v,
    // so a single add followed by dropping the fraction bits does it.
    always_comb begin
        tx = s2_vx_reg + ROUND_HALF
           - $signed({{(awba_pkg::SUM_W-1){1'b0}}, s2_vx_reg[awba_pkg::SUM_W-1]});
        ty = s2_vy_reg + ROUND_HALF
           - $signed({{(awba_pkg::SUM_W-1){1'b0}}, s2_vy_reg[awba_pkg::SUM_W-1]});
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_item_reg <= s2_item_reg;
            s3_sx_reg   <= tx[awba_pkg::SUM_W-1:awba_pkg::FRAC_BITS];
            s3_sy_reg   <= ty[awba_pkg::SUM_W-1:awba_pkg::FRAC_BITS];
        end
    end

    // ---------------- stage 3 -> frame banks ----------------
    assign inside_next = !s3_sx_reg[awba_pkg::RND_W-1] && (s3_sx_reg <= SX_MAX)
                      && !s3_sy_reg[awba_pkg::RND_W-1] && (s3_sy_reg <= SY_MAX);

    // Bank {y[0], x[0]} holds the pixels of that parity; each bank supplies
    // exactly one corner of any 2x2 block. An even bank column is one past
    // the half coordinate when the block starts on an odd column.
    always_comb begin
        col_inc  = {1'b0, s3_sx_reg[COL_W:1]} + {{COL_W{1'b0}}, s3_sx_reg[0]};
        row_inc  = {1'b0, s3_sy_reg[ROW_W:1]} + {{ROW_W{1'b0}}, s3_sy_reg[0]};
        col_even = col_inc[COL_W-1:0];
        row_even = row_inc[ROW_W-1:0];
        col_odd  = s3_sx_reg[COL_W:1];
        row_odd  = s3_sy_reg[ROW_W:1];
    end

    assign wx_ext   = {{(POS_EXT_W_L-awba_pkg::POS_W){1'b0}}, s3_item_reg.pos_x};
    assign wy_ext   = {{(POS_EXT_W_L-awba_pkg::POS_W){1'b0}}, s3_item_reg.pos_y};
    assign waddr    = {wy_ext[ROW_W:1], wx_ext[COL_W:1]};
    assign wbank    = {s3_item_reg.pos_y[0], s3_item_reg.pos_x[0]};
    assign s3_write = adv && s3_valid_reg && (s3_item_reg.req_type == awba_pkg::REQ_WRITE);

    for (genvar b = 0; b < awba_pkg::CORNER_COUNT; b++) begin : g_bank
        localparam logic BX = (b % 2) == 1;
        localparam logic BY = (b / 2) == 1;

        logic [COL_W+ROW_W-1:0] raddr;

        assign raddr = {(BY ? row_odd : row_even), (BX ? col_odd : col_even)};

        awba_ram #(
            .WIDTH (awba_pkg::PIX_W),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .aclk  (aclk),
            .we    (s3_write && (wbank == 2'(b))),
            .waddr (waddr),
            .wdata (s3_item_reg.pixel_rgb),
            .re    (adv),
            .raddr (raddr),
            .rdata (rd_data[b])
        );
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_query_reg  <= (s3_item_reg.req_type == awba_pkg::REQ_QUERY);
            s4_inside_reg <= inside_next;
        end
    end

    // ---------------- stage 4 -> output ----------------
    always_comb begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int k = 0; k < awba_pkg::CORNER_COUNT; k++) begin
            sum_r = sum_r + awba_pkg::CH_SUM_W'(rd_data[k][23:16]);
            sum_g = sum_g + awba_pkg::CH_SUM_W'(rd_data[k][15:8]);
            sum_b = sum_b + awba_pkg::CH_SUM_W'(rd_data[k][7:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (s4_inside_reg) begin
                // Divide by the four corners: drop two bits.
                red_reg    <= sum_r[awba_pkg::CH_SUM_W-1:2];
                green_reg  <= sum_g[awba_pkg::CH_SUM_W-1:2];
                blue_reg   <= sum_b[awba_pkg::CH_SUM_W-1:2];
                inside_reg <= 1'b1;
            end else begin
                red_reg    <= awba_pkg::CH_WHITE;
                green_reg  <= awba_pkg::CH_WHITE;
                blue_reg   <= awba_pkg::CH_WHITE;
                inside_reg <= 1'b0;
            end
        end
    end

    // Stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= q_head.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            m_valid_reg  <= s4_valid_reg && s4_query_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_red    = red_reg;
    assign m_out_green  = green_reg;
    assign m_out_blue   = blue_reg;
    assign m_inside_res = inside_reg;

endmodule

>>> design/affine_warp_box_average_unit.sv
// ============================================================================
// affine_warp_box_average_unit
// Affine inverse-mapping image warp with a 2x2 box average over a banked
// source frame store.
// ============================================================================
// Path: a query accepted by the front end is queued, then passes four back-end
//   stages and the output register before its result shows on m_valid.
// Throughput: one item per cycle while m_ready is high; the four parity banks
//   of the frame store give all four corners of a block in a single read.
// Reset: aresetn is synchronous, active low. It empties the queue and the
//   pipeline and loads the identity matrix; the frame store is not cleared.
// ============================================================================
module affine_warp_box_average_unit #(
    parameter int FRAME_WIDTH  = 512,
    parameter int FRAME_HEIGHT = 512
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [awba_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [awba_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [awba_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,

    // Input items
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_req_type,
    input  logic [awba_pkg::POS_W-1:0]        s_pos_x,
    input  logic [awba_pkg::POS_W-1:0]        s_pos_y,
    input  logic [awba_pkg::PIX_W-1:0]        s_pixel_rgb,

    // Result items
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [awba_pkg::CH_W-1:0]         m_out_red,
    output logic [awba_pkg::CH_W-1:0]         m_out_green,
    output logic [awba_pkg::CH_W-1:0]         m_out_blue,
    output logic                              m_inside_res
);

    awba_pkg::coef_t                  coef_reg;
    awba_pkg::queue_head_t            q_head;
    logic                             q_pop;
    logic                             cfg_write;
    logic [awba_pkg::REG_IDX_W-1:0]   reg_idx;

    // Registers sit on 32-bit word addresses; the access phase of a write
    // updates the register. The port never inserts wait states.
    assign pready    = 1'b1;
    assign reg_idx   = paddr[awba_pkg::APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg.coef_xx  <= awba_pkg::COEF_ONE;
            coef_reg.coef_xy  <= awba_pkg::COEF_ZERO;
            coef_reg.offset_x <= awba_pkg::COEF_ZERO;
            coef_reg.coef_yx  <= awba_pkg::COEF_ZERO;
            coef_reg.coef_yy  <= awba_pkg::COEF_ONE;
            coef_reg.offset_y <= awba_pkg::COEF_ZERO;
        end else if (cfg_write) begin
            case (reg_idx)
                awba_pkg::REG_COEF_XX:  coef_reg.coef_xx  <= pwdata;
                awba_pkg::REG_COEF_XY:  coef_reg.coef_xy  <= pwdata;
                awba_pkg::REG_OFFSET_X: coef_reg.offset_x <= pwdata;
                awba_pkg::REG_COEF_YX:  coef_reg.coef_yx  <= pwdata;
                awba_pkg::REG_COEF_YY:  coef_reg.coef_yy  <= pwdata;
                awba_pkg::REG_OFFSET_Y: coef_reg.offset_y <= pwdata;
                default: begin
                    // Addresses past the last register are ignored.
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            awba_pkg::REG_COEF_XX:  prdata = coef_reg.coef_xx;
            awba_pkg::REG_COEF_XY:  prdata = coef_reg.coef_xy;
            awba_pkg::REG_OFFSET_X: prdata = coef_reg.offset_x;
            awba_pkg::REG_COEF_YX:  prdata = coef_reg.coef_yx;
            awba_pkg::REG_COEF_YY:  prdata = coef_reg.coef_yy;
            awba_pkg::REG_OFFSET_Y: prdata = coef_reg.offset_y;
            default:                prdata = '0;
        endcase
    end

    // The front end takes items and filters writes outside the frame; its
    // queue lets it accept while the back end waits on m_ready, until it is full.
    awba_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_pos_x     (s_pos_x),
        .s_pos_y     (s_pos_y),
        .s_pixel_rgb (s_pixel_rgb),
        .q_head      (q_head),
        .q_pop       (q_pop)
    );

    // The back end executes writes and queries strictly in order, so a query
    // always sees every earlier write to the frame store.
    awba_back #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .coef         (coef_reg),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_red    (m_out_red),
        .m_out_green  (m_out_green),
        .m_out_blue   (m_out_blue),
        .m_inside_res (m_inside_res)
    );

endmodule

>>> design/awba_checker.sv
// ============================================================================
// awba_checker
// Port-level checks of the affine warp box-average unit.
// ============================================================================
module awba_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       s_req_type,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [awba_pkg::CH_W-1:0]  m_out_red,
    input logic [awba_pkg::CH_W-1:0]  m_out_green,
    input logic [awba_pkg::CH_W-1:0]  m_out_blue,
    input logic                       m_inside_res
);

    logic [7:0] pending_reg;
    logic       query_in;
    logic       result_out;

    assign query_in   = s_valid && s_ready && (s_req_type == awba_pkg::REQ_QUERY);
    assign result_out = m_valid && m_ready;

    // Queries accepted whose results are not yet taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_reg + 8'(query_in) - 8'(result_out);
        end
    end

    a_result_has_query: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (pending_reg != 8'd0))
        else $error("result offered with no outstanding query");

    a_outside_is_white: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_inside_res) |->
            (m_out_red == awba_pkg::CH_WHITE) && (m_out_green == awba_pkg::CH_WHITE)
            && (m_out_blue == awba_pkg::CH_WHITE))
        else $error("outside result is not white");

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            m_valid && $stable({m_out_red, m_out_green, m_out_blue, m_inside_res}))
        else $error("stalled result changed");

endmodule

bind affine_warp_box_average_unit awba_checker u_awba_checker (.*);
